// ----- rtl/mrtb_pkg.sv -----
`default_nettype none

package mrtb_pkg;

    // Field and register widths
    localparam int TS_W        = 48;
    localparam int LEN_W       = 14;
    localparam int COLOR_W     = 2;
    localparam int RATE_W      = 32;
    localparam int BURST_W     = 24;
    localparam int TOTAL_W     = 64;
    localparam int FRAC_W      = 16;
    localparam int MUL_W       = 32;
    localparam int PROD_W      = 2 * MUL_W;

    // Bucket counts: only the first REG_BUCKETS buckets have registers
    localparam int REG_BUCKETS     = 2;
    localparam int NUM_BUCKETS_DEF = 2;

    // APB port
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = 3;

    // Cost of one packet in packet mode
    localparam logic [LEN_W-1:0] PACKET_COST = LEN_W'(1);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ENABLE,
        REG_COUNT_PKTS,
        REG_FIRST_RATE,
        REG_FIRST_BURST,
        REG_SECOND_RATE,
        REG_SECOND_BURST
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_DIFF,
        ST_FILL,
        ST_DECIDE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                                 enable;
        logic                                 count_packets;
        logic [REG_BUCKETS-1:0][RATE_W-1:0]   rate;
        logic [REG_BUCKETS-1:0][BURST_W-1:0]  burst;
        logic                                 refill;
    } mrtb_cfg_t;

endpackage

`default_nettype wire

// ----- rtl/mrtb_if.sv -----
`default_nettype none

// Packet descriptor channel
interface mrtb_in_if;
    import mrtb_pkg::*;

    logic             valid;
    logic             ready;
    logic [TS_W-1:0]  timestamp_us;
    logic [LEN_W-1:0] packet_length;

    modport source (output valid, output timestamp_us, output packet_length, input ready);
    modport sink   (input valid, input timestamp_us, input packet_length, output ready);
endinterface

// Color result channel
interface mrtb_out_if;
    import mrtb_pkg::*;

    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] color;

    modport source (output valid, output color, input ready);
    modport sink   (input valid, input color, output ready);
endinterface

`default_nettype wire

// ----- rtl/multi_rate_token_bucket_meter.sv -----
// Two-rate token-bucket packet meter.
// pkt_in carries one packet descriptor per transfer (timestamp_us, packet_length);
// pkt_out returns one color per packet: 0 conforms, k means bucket k-1 was short.
// Configuration goes through the APB port, one 32-bit register every 4 bytes;
// a write to any defined register refills every bucket to its burst size and
// clears the credited totals. pready is always high.
// Timing: one item at a time. A disabled meter goes straight from idle to its
// last step and returns the color from there. Enabled, each checked bucket takes
// two passes through the shared 32x32 multiplier, then sum, difference, fill and
// decide steps; checking stops at the first short bucket or after the last one,
// so up to 2 buckets are checked.
// The cycle after a register write, pkt_in.ready stays low while buckets refill.
// Reset clears the configuration registers, empties the buckets and drops any pending color.
// A stalled receiver holds the color in the output register; a finished packet
// then waits in its last step, and pkt_in.ready stays low until the color moves.
`default_nettype none

module multi_rate_token_bucket_meter #(
    parameter int NUM_BUCKETS = mrtb_pkg::NUM_BUCKETS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    mrtb_in_if.sink                          pkt_in,
    mrtb_out_if.source                       pkt_out,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mrtb_pkg::APB_AW-1:0] paddr,
    input  wire logic [mrtb_pkg::APB_DW-1:0] pwdata,
    output logic      [mrtb_pkg::APB_DW-1:0] prdata,
    output logic                             pready
);
    import mrtb_pkg::*;

    logic                 enable_reg;
    logic                 count_packets_reg;
    logic [RATE_W-1:0]    first_rate_reg;
    logic [BURST_W-1:0]   first_burst_reg;
    logic [RATE_W-1:0]    second_rate_reg;
    logic [BURST_W-1:0]   second_burst_reg;
    logic                 refill_reg;

    logic                 wr_en;
    logic                 wr_hit;
    reg_idx_t             reg_idx;
    mrtb_cfg_t            cfg;
    logic [MUL_W-1:0]     mul_a;
    logic [MUL_W-1:0]     mul_b;
    logic [PROD_W-1:0]    mul_p;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = reg_idx_t'(paddr[APB_AW-1:2]);

    // Decode register index and read data
    always_comb
    begin
        wr_hit = 1'b1;
        case (reg_idx)
            REG_ENABLE:       prdata = APB_DW'(enable_reg);
            REG_COUNT_PKTS:   prdata = APB_DW'(count_packets_reg);
            REG_FIRST_RATE:   prdata = first_rate_reg;
            REG_FIRST_BURST:  prdata = APB_DW'(first_burst_reg);
            REG_SECOND_RATE:  prdata = second_rate_reg;
            REG_SECOND_BURST: prdata = APB_DW'(second_burst_reg);
            default:
            begin
                prdata = '0;
                wr_hit = 1'b0;
            end
        endcase
    end

    // Register writes; flag a refill for the cycle after
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg        <= 1'b0;
            count_packets_reg <= 1'b0;
            first_rate_reg    <= '0;
            first_burst_reg   <= '0;
            second_rate_reg   <= '0;
            second_burst_reg  <= '0;
            refill_reg        <= 1'b0;
        end
        else
        begin
            refill_reg <= wr_en && wr_hit;
            if (wr_en)
            begin
                case (reg_idx)
                    REG_ENABLE:       enable_reg        <= pwdata[0];
                    REG_COUNT_PKTS:   count_packets_reg <= pwdata[0];
                    REG_FIRST_RATE:   first_rate_reg    <= pwdata[RATE_W-1:0];
                    REG_FIRST_BURST:  first_burst_reg   <= pwdata[BURST_W-1:0];
                    REG_SECOND_RATE:  second_rate_reg   <= pwdata[RATE_W-1:0];
                    REG_SECOND_BURST: second_burst_reg  <= pwdata[BURST_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign cfg.enable        = enable_reg;
    assign cfg.count_packets = count_packets_reg;
    assign cfg.rate[0]       = first_rate_reg;
    assign cfg.rate[1]       = second_rate_reg;
    assign cfg.burst[0]      = first_burst_reg;
    assign cfg.burst[1]      = second_burst_reg;
    assign cfg.refill        = refill_reg;

    mrtb_core #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .pkt_in  (pkt_in),
        .pkt_out (pkt_out),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .mul_p   (mul_p)
    );

    mrtb_mul u_mul (
        .clk   (clk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .mul_p (mul_p)
    );

`ifndef SYNTHESIS
    // One packet in flight: ready drops right after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (pkt_in.valid && pkt_in.ready) |=> !pkt_in.ready)
        else $error("meter accepted a packet while busy");

    // Hold off packets during the refill after a register write
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && wr_hit) |=> !pkt_in.ready)
        else $error("packet accepted during bucket refill");

    // Color never names a bucket beyond the configured count
    assert property (@(posedge clk) disable iff (!rst_n)
        pkt_out.valid |-> (pkt_out.color <= COLOR_W'(NUM_BUCKETS)))
        else $error("color out of range");
`endif

endmodule

`default_nettype wire

// ----- rtl/mrtb_mul.sv -----
`default_nettype none

module mrtb_mul (
    input  wire logic                        clk,
    input  wire logic [mrtb_pkg::MUL_W-1:0]  mul_a,
    input  wire logic [mrtb_pkg::MUL_W-1:0]  mul_b,
    output logic      [mrtb_pkg::PROD_W-1:0] mul_p
);
    import mrtb_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    // Register the full product of one partial multiplication
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    assign mul_p = prod_reg;

endmodule

`default_nettype wire

// ----- rtl/mrtb_core.sv -----
`default_nettype none

module mrtb_core #(
    parameter int NUM_BUCKETS = mrtb_pkg::NUM_BUCKETS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire mrtb_pkg::mrtb_cfg_t         cfg,
    mrtb_in_if.sink                          pkt_in,
    mrtb_out_if.source                       pkt_out,
    output logic      [mrtb_pkg::MUL_W-1:0]  mul_a,
    output logic      [mrtb_pkg::MUL_W-1:0]  mul_b,
    input  wire logic [mrtb_pkg::PROD_W-1:0] mul_p
);
    import mrtb_pkg::*;

    localparam int ACTIVE = (NUM_BUCKETS < REG_BUCKETS) ? NUM_BUCKETS : REG_BUCKETS;
    localparam int IDX_W  = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     bkt_reg, bkt_next;
    logic                 out_valid_reg, out_valid_next;
    logic [COLOR_W-1:0]   out_color_reg, out_color_next;
    logic [TS_W-1:0]      ts_reg, ts_next;
    logic [LEN_W-1:0]     cost_reg, cost_next;
    logic [MUL_W-1:0]     lo_part_reg, lo_part_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic [TOTAL_W-1:0]   add_reg, add_next;
    logic [BURST_W-1:0]   tok_reg, tok_next;
    logic [COLOR_W-1:0]   color_reg, color_next;
    logic [BURST_W-1:0]   tokens_reg [ACTIVE];
    logic [BURST_W-1:0]   tokens_next [ACTIVE];
    logic [TOTAL_W-1:0]   cred_reg [ACTIVE];
    logic [TOTAL_W-1:0]   cred_next [ACTIVE];

    logic                 accept;
    logic                 out_free;
    logic                 last_bkt;
    logic                 short_tok;
    logic [RATE_W-1:0]    rate_sel;
    logic [BURST_W-1:0]   burst_sel;
    logic [BURST_W-1:0]   room;

    assign accept    = pkt_in.valid && pkt_in.ready;
    assign out_free  = !out_valid_reg || pkt_out.ready;
    assign last_bkt  = (bkt_reg == IDX_W'(ACTIVE - 1));
    assign rate_sel  = cfg.rate[bkt_reg];
    assign burst_sel = cfg.burst[bkt_reg];
    assign room      = burst_sel - tok_reg;
    assign short_tok = (tok_reg < BURST_W'(cost_reg));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = cfg.enable ? ST_MUL_LO : ST_DONE;
                end
            end
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_SUM;
            ST_SUM:    state_next = ST_DIFF;
            ST_DIFF:   state_next = ST_FILL;
            ST_FILL:   state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                state_next = (short_tok || last_bkt) ? ST_DONE : ST_MUL_LO;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake and multiplier operands
    always_comb
    begin
        pkt_in.ready  = (state_reg == ST_IDLE) && !cfg.refill;
        pkt_out.valid = out_valid_reg;
        pkt_out.color = out_color_reg;
        mul_b         = rate_sel;
        case (state_reg)
            ST_MUL_LO: mul_a = MUL_W'(ts_reg[FRAC_W-1:0]);
            default:   mul_a = ts_reg[TS_W-1:FRAC_W];
        endcase
    end

    // Datapath and bucket state
    always_comb
    begin
        bkt_next       = bkt_reg;
        ts_next        = ts_reg;
        cost_next      = cost_reg;
        lo_part_next   = lo_part_reg;
        total_next     = total_reg;
        add_next       = add_reg;
        tok_next       = tok_reg;
        color_next     = color_reg;
        out_color_next = out_color_reg;
        out_valid_next = out_valid_reg;
        for (int i = 0; i < ACTIVE; i++)
        begin
            tokens_next[i] = tokens_reg[i];
            cred_next[i]   = cred_reg[i];
        end

        // Drop the result once the receiver takes it
        if (out_valid_reg && pkt_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        // Refill every bucket after a register write
        if (cfg.refill)
        begin
            for (int i = 0; i < ACTIVE; i++)
            begin
                tokens_next[i] = cfg.burst[i];
                cred_next[i]   = '0;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ts_next    = pkt_in.timestamp_us;
                    cost_next  = cfg.count_packets ? PACKET_COST : pkt_in.packet_length;
                    bkt_next   = '0;
                    color_next = '0;
                end
            end
            ST_MUL_HI:
            begin
                // Fraction part: (lo * rate) >> 16
                lo_part_next = mul_p[FRAC_W +: MUL_W];
            end
            ST_SUM:
            begin
                total_next = mul_p + TOTAL_W'(lo_part_reg);
            end
            ST_DIFF:
            begin
                if (total_reg > cred_reg[bkt_reg])
                begin
                    add_next           = total_reg - cred_reg[bkt_reg];
                    cred_next[bkt_reg] = total_reg;
                end
                else
                begin
                    add_next = '0;
                end
                tok_next = (tokens_reg[bkt_reg] > burst_sel) ? burst_sel : tokens_reg[bkt_reg];
            end
            ST_FILL:
            begin
                // Saturate at burst size
                if (add_reg >= TOTAL_W'(room))
                begin
                    tok_next = burst_sel;
                end
                else
                begin
                    tok_next = tok_reg + add_reg[BURST_W-1:0];
                end
            end
            ST_DECIDE:
            begin
                if (short_tok)
                begin
                    tokens_next[bkt_reg] = tok_reg;
                    color_next           = COLOR_W'(bkt_reg) + COLOR_W'(1);
                end
                else
                begin
                    tokens_next[bkt_reg] = tok_reg - BURST_W'(cost_reg);
                    if (!last_bkt)
                    begin
                        bkt_next = bkt_reg + IDX_W'(1);
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_color_next = color_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control and bucket state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bkt_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ACTIVE; i++)
            begin
                tokens_reg[i] <= '0;
                cred_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            bkt_reg       <= bkt_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < ACTIVE; i++)
            begin
                tokens_reg[i] <= tokens_next[i];
                cred_reg[i]   <= cred_next[i];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ts_reg        <= ts_next;
        cost_reg      <= cost_next;
        lo_part_reg   <= lo_part_next;
        total_reg     <= total_next;
        add_reg       <= add_next;
        tok_reg       <= tok_next;
        color_reg     <= color_next;
        out_color_reg <= out_color_next;
    end

endmodule

`default_nettype wire
